[sv/rdcc_pkg.sv]
// Package with shared types, command codes and register constants for the drive controller.
`timescale 1ns / 1ps

package rdcc_pkg;

    // Field widths
    localparam int OP_W   = 2;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 16;
    localparam int DUTY_W = 16;

    // Configuration port geometry
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // Event kinds
    localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_W-1:0] OP_RX_BYTE = 2'd1;
    localparam logic [OP_W-1:0] OP_BUTTON  = 2'd2;
    localparam logic [OP_W-1:0] OP_BATTERY = 2'd3;

    // Received command bytes
    localparam logic [BYTE_W-1:0] CMD_FORWARD = 8'd70;
    localparam logic [BYTE_W-1:0] CMD_STOP    = 8'd66;
    localparam logic [BYTE_W-1:0] CMD_RIGHT   = 8'd82;
    localparam logic [BYTE_W-1:0] CMD_LEFT    = 8'd76;
    localparam logic [BYTE_W-1:0] CMD_IGNORED = 8'd83;
    localparam logic [BYTE_W-1:0] CMD_NONE    = 8'd0;

    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_BATT_THRESHOLD = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BATT_CHECK     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LEFT_DUTY      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RIGHT_DUTY     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FWD_HOLDOFF    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BTN_HOLDOFF    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SHORT_TURN     = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_LONG_PRESS     = 3'd7;

    // Register reset values
    localparam logic [BYTE_W-1:0] RST_BATT_THRESHOLD = 8'd232;
    localparam logic [CNT_W-1:0]  RST_BATT_CHECK     = 16'd1000;
    localparam logic [DUTY_W-1:0] RST_LEFT_DUTY      = 16'd20300;
    localparam logic [DUTY_W-1:0] RST_RIGHT_DUTY     = 16'd22470;
    localparam logic [CNT_W-1:0]  RST_FWD_HOLDOFF    = 16'd70;
    localparam logic [CNT_W-1:0]  RST_BTN_HOLDOFF    = 16'd70;
    localparam logic [CNT_W-1:0]  RST_SHORT_TURN     = 16'd224;
    localparam logic [CNT_W-1:0]  RST_LONG_PRESS     = 16'd250;

    // Configuration bundle handed to the event logic
    typedef struct packed {
        logic [BYTE_W-1:0] battery_threshold;
        logic [CNT_W-1:0]  battery_check_ticks;
        logic [DUTY_W-1:0] left_drive_duty;
        logic [DUTY_W-1:0] right_drive_duty;
        logic [CNT_W-1:0]  forward_holdoff_ticks;
        logic [CNT_W-1:0]  button_holdoff_ticks;
        logic [CNT_W-1:0]  short_turn_ticks;
        logic [CNT_W-1:0]  long_press_ticks;
    } cfg_t;

    // One result item
    typedef struct packed {
        logic              running;
        logic              sample_request;
        logic              low_battery_led;
        logic              left_turn_pin;
        logic              right_turn_pin;
        logic [DUTY_W-1:0] right_duty;
        logic [DUTY_W-1:0] left_duty;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int M_DATA_W = ((RESULT_W + 7) / 8) * 8;

    // Saturating counter increment
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (c == CNT_MAX) ? c : c + 16'd1;
    endfunction

endpackage

[sv/rdcc_cfg_regs.sv]
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module rdcc_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rdcc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [rdcc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rdcc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output rdcc_pkg::cfg_t                    cfg
);
    import rdcc_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    // Write decode: one register per word address
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_BATT_THRESHOLD: cfg_next.battery_threshold     = pwdata[BYTE_W-1:0];
                REG_BATT_CHECK:     cfg_next.battery_check_ticks   = pwdata[CNT_W-1:0];
                REG_LEFT_DUTY:      cfg_next.left_drive_duty       = pwdata[DUTY_W-1:0];
                REG_RIGHT_DUTY:     cfg_next.right_drive_duty      = pwdata[DUTY_W-1:0];
                REG_FWD_HOLDOFF:    cfg_next.forward_holdoff_ticks = pwdata[CNT_W-1:0];
                REG_BTN_HOLDOFF:    cfg_next.button_holdoff_ticks  = pwdata[CNT_W-1:0];
                REG_SHORT_TURN:     cfg_next.short_turn_ticks      = pwdata[CNT_W-1:0];
                REG_LONG_PRESS:     cfg_next.long_press_ticks      = pwdata[CNT_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // Read decode
    always_comb
    begin
        unique case (reg_idx)
            REG_BATT_THRESHOLD: prdata = {24'd0, cfg_reg.battery_threshold};
            REG_BATT_CHECK:     prdata = {16'd0, cfg_reg.battery_check_ticks};
            REG_LEFT_DUTY:      prdata = {16'd0, cfg_reg.left_drive_duty};
            REG_RIGHT_DUTY:     prdata = {16'd0, cfg_reg.right_drive_duty};
            REG_FWD_HOLDOFF:    prdata = {16'd0, cfg_reg.forward_holdoff_ticks};
            REG_BTN_HOLDOFF:    prdata = {16'd0, cfg_reg.button_holdoff_ticks};
            REG_SHORT_TURN:     prdata = {16'd0, cfg_reg.short_turn_ticks};
            REG_LONG_PRESS:     prdata = {16'd0, cfg_reg.long_press_ticks};
            default:            prdata = '0;
        endcase
    end

    // Register storage with documented reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.battery_threshold     <= RST_BATT_THRESHOLD;
            cfg_reg.battery_check_ticks   <= RST_BATT_CHECK;
            cfg_reg.left_drive_duty       <= RST_LEFT_DUTY;
            cfg_reg.right_drive_duty      <= RST_RIGHT_DUTY;
            cfg_reg.forward_holdoff_ticks <= RST_FWD_HOLDOFF;
            cfg_reg.button_holdoff_ticks  <= RST_BTN_HOLDOFF;
            cfg_reg.short_turn_ticks      <= RST_SHORT_TURN;
            cfg_reg.long_press_ticks      <= RST_LONG_PRESS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[sv/rdcc_event_core.sv]
// Controller state and the per-event update followed by one control pass.
`timescale 1ns / 1ps

module rdcc_event_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [rdcc_pkg::OP_W-1:0]     opcode,
    input  logic [rdcc_pkg::BYTE_W-1:0]   rx_byte,
    input  logic [rdcc_pkg::BYTE_W-1:0]   battery_sample,
    input  rdcc_pkg::cfg_t                cfg,
    output rdcc_pkg::result_t             result
);
    import rdcc_pkg::*;

    // State registers
    logic              run_flag_reg,        run_flag_next;
    logic              move_flag_reg,       move_flag_next;
    logic [BYTE_W-1:0] pending_reg,         pending_next;
    logic [BYTE_W-1:0] last_byte_reg,       last_byte_next;
    logic [BYTE_W-1:0] battery_value_reg,   battery_value_next;
    logic [CNT_W-1:0]  button_cnt_reg,      button_cnt_next;
    logic [CNT_W-1:0]  battery_cnt_reg,     battery_cnt_next;
    logic [CNT_W-1:0]  forward_cnt_reg,     forward_cnt_next;
    logic [CNT_W-1:0]  turn_cnt_reg,        turn_cnt_next;
    logic              turn_pending_reg,    turn_pending_next;
    logic              short_turn_reg,      short_turn_next;
    logic              turn_is_right_reg,   turn_is_right_next;
    logic [1:0]        pin_levels_reg,      pin_levels_next;
    logic              led_level_reg,       led_level_next;
    logic              long_hold_reg,       long_hold_next;

    logic              sample_req;
    logic              pass_done;
    logic [BYTE_W-1:0] dir_byte;

    // Event update, then one pass of the control loop
    always_comb
    begin
        run_flag_next      = run_flag_reg;
        move_flag_next     = move_flag_reg;
        pending_next       = pending_reg;
        last_byte_next     = last_byte_reg;
        battery_value_next = battery_value_reg;
        button_cnt_next    = button_cnt_reg;
        battery_cnt_next   = battery_cnt_reg;
        forward_cnt_next   = forward_cnt_reg;
        turn_cnt_next      = turn_cnt_reg;
        turn_pending_next  = turn_pending_reg;
        short_turn_next    = short_turn_reg;
        turn_is_right_next = turn_is_right_reg;
        pin_levels_next    = pin_levels_reg;
        led_level_next     = led_level_reg;
        long_hold_next     = long_hold_reg;
        sample_req         = 1'b0;
        pass_done          = 1'b0;
        dir_byte           = turn_is_right_reg ? CMD_RIGHT : CMD_LEFT;

        if (step)
        begin
            // Event-specific update
            unique case (opcode)
                OP_TICK:
                begin
                    battery_cnt_next = sat_inc(battery_cnt_reg);
                    forward_cnt_next = sat_inc(forward_cnt_reg);
                    button_cnt_next  = sat_inc(button_cnt_reg);
                    if (turn_pending_reg)
                    begin
                        turn_cnt_next = sat_inc(turn_cnt_reg);
                    end
                    if (short_turn_reg && (turn_cnt_next >= cfg.short_turn_ticks))
                    begin
                        if (turn_is_right_reg)
                        begin
                            pin_levels_next[0] = 1'b1;
                        end
                        else
                        begin
                            pin_levels_next[1] = 1'b1;
                        end
                        turn_pending_next = 1'b0;
                        short_turn_next   = 1'b0;
                    end
                end
                OP_RX_BYTE:
                begin
                    last_byte_next = rx_byte;
                    if ((rx_byte != CMD_IGNORED) && run_flag_reg &&
                        !((forward_cnt_reg < cfg.forward_holdoff_ticks) &&
                          (rx_byte == CMD_FORWARD)))
                    begin
                        pending_next = rx_byte;
                    end
                end
                OP_BUTTON:
                begin
                    if (button_cnt_reg > cfg.button_holdoff_ticks)
                    begin
                        run_flag_next   = !run_flag_reg;
                        button_cnt_next = '0;
                    end
                end
                OP_BATTERY:
                begin
                    battery_value_next = battery_sample;
                end
                default:
                begin
                    battery_value_next = battery_value_reg;
                end
            endcase

            // Long hold keeps the pin low while the direction byte stays
            if (long_hold_reg)
            begin
                if (last_byte_next == dir_byte)
                begin
                    if (turn_is_right_next)
                    begin
                        pin_levels_next[0] = 1'b0;
                    end
                    else
                    begin
                        pin_levels_next[1] = 1'b0;
                    end
                    pass_done = 1'b1;
                end
                else
                begin
                    long_hold_next    = 1'b0;
                    turn_pending_next = 1'b0;
                    if (turn_is_right_next)
                    begin
                        pin_levels_next[0] = 1'b1;
                    end
                    else
                    begin
                        pin_levels_next[1] = 1'b1;
                    end
                    pending_next = CMD_NONE;
                end
            end

            if (!pass_done && !run_flag_next)
            begin
                move_flag_next = 1'b0;
                pending_next   = CMD_NONE;
            end
            else if (!pass_done)
            begin
                // Periodic battery check
                if (battery_cnt_next >= cfg.battery_check_ticks)
                begin
                    sample_req       = 1'b1;
                    led_level_next   = (battery_value_next < cfg.battery_threshold);
                    battery_cnt_next = '0;
                end

                // Pending command decode
                if (pending_next == CMD_FORWARD)
                begin
                    move_flag_next   = !move_flag_next;
                    pending_next     = CMD_NONE;
                    forward_cnt_next = '0;
                end
                else if (pending_next == CMD_STOP)
                begin
                    move_flag_next  = 1'b0;
                    pending_next    = CMD_NONE;
                    pin_levels_next = 2'b11;
                end
                else if ((pending_next == CMD_RIGHT) || (pending_next == CMD_LEFT))
                begin
                    if (move_flag_next && !turn_pending_next)
                    begin
                        turn_cnt_next      = '0;
                        turn_pending_next  = 1'b1;
                        turn_is_right_next = (pending_next == CMD_RIGHT);
                    end
                    pending_next = CMD_NONE;
                end

                // Short press: direction byte no longer present within the window
                if (turn_pending_next && (turn_cnt_next > 16'd1) &&
                    (turn_cnt_next <= cfg.long_press_ticks))
                begin
                    if (turn_is_right_next && (last_byte_next != CMD_RIGHT))
                    begin
                        pin_levels_next[0] = 1'b0;
                        short_turn_next    = 1'b1;
                        pending_next       = CMD_NONE;
                    end
                    if (!turn_is_right_next && (last_byte_next != CMD_LEFT))
                    begin
                        pin_levels_next[1] = 1'b0;
                        short_turn_next    = 1'b1;
                        pending_next       = CMD_NONE;
                    end
                end

                // Long press: hold while the direction byte persists
                if (turn_pending_next && (turn_cnt_next > cfg.long_press_ticks))
                begin
                    if (last_byte_next == (turn_is_right_next ? CMD_RIGHT : CMD_LEFT))
                    begin
                        if (turn_is_right_next)
                        begin
                            pin_levels_next[0] = 1'b0;
                        end
                        else
                        begin
                            pin_levels_next[1] = 1'b0;
                        end
                        long_hold_next = 1'b1;
                    end
                    else
                    begin
                        turn_pending_next = 1'b0;
                        if (turn_is_right_next)
                        begin
                            pin_levels_next[0] = 1'b1;
                        end
                        else
                        begin
                            pin_levels_next[1] = 1'b1;
                        end
                        pending_next = CMD_NONE;
                    end
                end
            end
        end
    end

    // Result of the current event
    always_comb
    begin
        result.left_duty       = move_flag_next ? cfg.left_drive_duty : '0;
        result.right_duty      = move_flag_next ? cfg.right_drive_duty : '0;
        result.right_turn_pin  = pin_levels_next[0];
        result.left_turn_pin   = pin_levels_next[1];
        result.low_battery_led = led_level_next;
        result.sample_request  = sample_req;
        result.running         = run_flag_next;
    end

    // State storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_flag_reg      <= 1'b0;
            move_flag_reg     <= 1'b0;
            pending_reg       <= CMD_NONE;
            last_byte_reg     <= '0;
            battery_value_reg <= '0;
            button_cnt_reg    <= '0;
            battery_cnt_reg   <= '0;
            forward_cnt_reg   <= '0;
            turn_cnt_reg      <= '0;
            turn_pending_reg  <= 1'b0;
            short_turn_reg    <= 1'b0;
            turn_is_right_reg <= 1'b0;
            pin_levels_reg    <= 2'b11;
            led_level_reg     <= 1'b0;
            long_hold_reg     <= 1'b0;
        end
        else
        begin
            run_flag_reg      <= run_flag_next;
            move_flag_reg     <= move_flag_next;
            pending_reg       <= pending_next;
            last_byte_reg     <= last_byte_next;
            battery_value_reg <= battery_value_next;
            button_cnt_reg    <= button_cnt_next;
            battery_cnt_reg   <= battery_cnt_next;
            forward_cnt_reg   <= forward_cnt_next;
            turn_cnt_reg      <= turn_cnt_next;
            turn_pending_reg  <= turn_pending_next;
            short_turn_reg    <= short_turn_next;
            turn_is_right_reg <= turn_is_right_next;
            pin_levels_reg    <= pin_levels_next;
            led_level_reg     <= led_level_next;
            long_hold_reg     <= long_hold_next;
        end
    end

endmodule

[sv/remote_drive_command_controller_core.sv]
// Top level of the remote drive command controller: stream ports, input and result registers.
`timescale 1ns / 1ps

// Usage:
// Events enter on the slave stream. s_tuser carries the event kind (tick,
// received byte, button press, battery sample); s_tdata carries the received
// byte and the battery sample. Each event produces exactly one result transfer
// on the master stream with the motor duties, direction pin levels, the
// low-battery LED, a conversion request flag and the run flag.
// An accepted transfer is first captured in the input register; then the event
// logic updates the controller state and loads the result register. Throughput
// is one event per cycle while the receiver does not stall the master stream.
// When the receiver stalls, the result register holds its transfer and one
// more event may wait in the input register; s_tready drops only when both
// are full. Reset clears both stages and returns the controller state and the
// configuration registers to their documented defaults; the pins reset high.
// The user writes configuration over the APB-style port only while the block
// is idle; the block itself does not enforce this.
module remote_drive_command_controller_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // Slave stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,  // [7:0] rx_byte, [15:8] battery_sample
    input  logic [rdcc_pkg::OP_W-1:0]         s_tuser,  // [1:0] opcode
    // Master stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] left_duty, [31:16] right_duty, [32] right_turn_pin, [33] left_turn_pin,
    // [34] low_battery_led, [35] sample_request, [36] running, [39:37] zero
    output logic [rdcc_pkg::M_DATA_W-1:0]     m_tdata,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rdcc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [rdcc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rdcc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import rdcc_pkg::*;

    cfg_t              cfg;
    result_t           result;

    logic              in_valid_reg;
    logic [OP_W-1:0]   in_op_reg;
    logic [BYTE_W-1:0] in_rx_reg;
    logic [BYTE_W-1:0] in_smp_reg;
    logic              out_valid_reg;
    result_t           out_data_reg;

    logic              advance;
    logic              step;
    logic              in_take;

    // Configuration registers
    rdcc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Event logic and controller state
    rdcc_event_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .opcode         (in_op_reg),
        .rx_byte        (in_rx_reg),
        .battery_sample (in_smp_reg),
        .cfg            (cfg),
        .result         (result)
    );

    // Handshake control
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg  <= s_tuser;
            in_rx_reg  <= s_tdata[BYTE_W-1:0];
            in_smp_reg <= s_tdata[2*BYTE_W-1:BYTE_W];
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - RESULT_W){1'b0}}, out_data_reg};

endmodule
